@@ sv/energy_vad_endpointer_defines.svh @@
// Assertion macros shared by the endpointer RTL.
`ifndef ENERGY_VAD_ENDPOINTER_DEFINES_SVH
`define ENERGY_VAD_ENDPOINTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, held off while reset is high.
`define EVEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds through reset.
`define EVEP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EVEP_ASSERT(lbl, prop, msg)
`define EVEP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ sv/evep_pkg.sv @@
package evep_pkg;

  // Frame length limit, overridable on the top level
  localparam int unsigned FRAME_MAX_DEFAULT = 2048;

  // Field and register widths
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned SQ_W          = 31;
  localparam int unsigned THR_W         = 21;
  localparam int unsigned THR_SCALED_W  = 31;
  localparam int unsigned MS_W          = 20;
  localparam int unsigned TAIL_W        = 16;
  localparam int unsigned MIN_UTT_W     = 16;
  localparam int unsigned TOTAL_W       = 32;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned CFG_DATA_W    = 21;

  // Mean square is compared in units of 1000
  localparam logic [THR_SCALED_W-1:0] THR_SCALE        = THR_SCALED_W'(1000);
  localparam logic [TOTAL_W-1:0]      BYTES_PER_SAMPLE = TOTAL_W'(2);
  localparam logic [MS_W-1:0]         MS_MAX           = '1;

  // Register reset values
  localparam logic [THR_SCALED_W-1:0] THR_SCALED_RESET = THR_SCALED_W'(300 * 1000);
  localparam logic [MS_W-1:0]         TIMEOUT_RESET    = MS_W'(10000);
  localparam logic [TAIL_W-1:0]       TAIL_RESET       = TAIL_W'(800);
  localparam logic [MIN_UTT_W-1:0]    MIN_UTT_RESET    = MIN_UTT_W'(300);

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SPEECH_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LISTEN_TIMEOUT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_SILENCE     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_UTTERANCE    = 2'd3;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_TICK,
    OP_STOP,
    OP_START
  } evep_op_t;

  typedef enum logic [1:0] {
    CAUSE_RUNNING,
    CAUSE_STOPPED,
    CAUSE_TIMEOUT,
    CAUSE_ENDPOINT
  } evep_cause_t;

  // Live configuration; the threshold is kept premultiplied by the scale
  typedef struct packed {
    logic [THR_SCALED_W-1:0] thr_scaled;
    logic [MS_W-1:0]         timeout;
    logic [TAIL_W-1:0]       tail;
    logic [MIN_UTT_W-1:0]    min_utt;
  } evep_cfg_t;

  // Registered input item, sample already squared
  typedef struct packed {
    logic [1:0]      op;
    logic [SQ_W-1:0] sq;
    logic            last;
  } evep_item_t;

  typedef struct packed {
    logic               session_done;
    logic [1:0]         end_cause;
    logic               frame_end;
    logic               frame_speech;
    logic               forward_frame;
    logic               utterance_seen;
    logic [TOTAL_W-1:0] frame_total;
    logic [TOTAL_W-1:0] byte_total;
  } evep_result_t;

endpackage

@@ sv/evep_ifs.sv @@
interface evep_in_if;
  import evep_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       last_of_frame;

  modport source (output valid, output operation, output sample_value,
                  output last_of_frame, input ready);
  modport sink (input valid, input operation, input sample_value,
                input last_of_frame, output ready);
endinterface

interface evep_out_if;
  import evep_pkg::*;

  logic               valid;
  logic               ready;
  logic               session_done;
  logic [1:0]         end_cause;
  logic               frame_end;
  logic               frame_speech;
  logic               forward_frame;
  logic               utterance_seen;
  logic [TOTAL_W-1:0] frame_total;
  logic [TOTAL_W-1:0] byte_total;

  modport source (output valid, output session_done, output end_cause,
                  output frame_end, output frame_speech, output forward_frame,
                  output utterance_seen, output frame_total, output byte_total,
                  input ready);
  modport sink (input valid, input session_done, input end_cause,
                input frame_end, input frame_speech, input forward_frame,
                input utterance_seen, input frame_total, input byte_total,
                output ready);
endinterface

@@ sv/evep_cfg.sv @@
module evep_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_en,
  input  logic [evep_pkg::CFG_INDEX_W-1:0] index,
  input  logic [evep_pkg::CFG_DATA_W-1:0]  data,
  output evep_pkg::evep_cfg_t              cfg
);
  import evep_pkg::*;

  logic [THR_SCALED_W-1:0] thr_scaled;
  logic [MS_W-1:0]         timeout;
  logic [TAIL_W-1:0]       tail;
  logic [MIN_UTT_W-1:0]    min_utt;

  // Store registers; scale the threshold once at write time
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_scaled <= THR_SCALED_RESET;
      timeout    <= TIMEOUT_RESET;
      tail       <= TAIL_RESET;
      min_utt    <= MIN_UTT_RESET;
    end else if (write_en) begin
      unique case (index)
        REG_SPEECH_THRESHOLD: begin
          thr_scaled <= THR_SCALED_W'(data[THR_W-1:0]) * THR_SCALE;
        end
        REG_LISTEN_TIMEOUT: begin
          timeout <= data[MS_W-1:0];
        end
        REG_TAIL_SILENCE: begin
          tail <= data[TAIL_W-1:0];
        end
        REG_MIN_UTTERANCE: begin
          min_utt <= data[MIN_UTT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.thr_scaled = thr_scaled;
  assign cfg.timeout    = timeout;
  assign cfg.tail       = tail;
  assign cfg.min_utt    = min_utt;

endmodule

@@ sv/evep_core.sv @@
`include "energy_vad_endpointer_defines.svh"

module evep_core #(
  parameter int unsigned FRAME_MAX = evep_pkg::FRAME_MAX_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  evep_pkg::evep_item_t   item,
  input  evep_pkg::evep_cfg_t    cfg,
  output evep_pkg::evep_result_t result
);
  import evep_pkg::*;

  localparam int unsigned CW    = $clog2(FRAME_MAX + 1);
  localparam int unsigned ESW   = SQ_W + CW;
  localparam int unsigned BW    = THR_SCALED_W + CW;
  localparam int unsigned CMP_W = (ESW > BW) ? ESW : BW;
  localparam logic [CW-1:0] COUNT_FULL = CW'(FRAME_MAX);

  // Session state
  logic [ESW-1:0]     energy_sum,      energy_sum_next;
  logic [CW-1:0]      frame_count,     frame_count_next;
  logic [MS_W-1:0]    elapsed,         elapsed_next;
  logic [MS_W-1:0]    last_speech,     last_speech_next;
  logic               speech_valid,    speech_valid_next;
  logic               utterance,       utterance_next;
  logic               ended,           ended_next;
  evep_cause_t        reason,          reason_next;
  logic [TOTAL_W-1:0] frames,          frames_next;
  logic [TOTAL_W-1:0] bytes,           bytes_next;

  // Datapath terms
  evep_op_t        op;
  logic [ESW-1:0]  sum_add;
  logic [CW-1:0]   count_inc;
  logic [BW-1:0]   bound;
  logic            speech_hit;
  logic            closing;
  logic [MS_W-1:0] elapsed_inc;
  logic            utt_after;
  logic            valid_after;
  logic [MS_W-1:0] last_after;
  logic [MS_W-1:0] gap;
  logic            closed;

  assign op          = evep_op_t'(item.op);
  assign sum_add     = energy_sum + ESW'(item.sq);
  assign count_inc   = frame_count + CW'(1);
  assign bound       = BW'(cfg.thr_scaled) * BW'(count_inc);
  assign speech_hit  = CMP_W'(sum_add) >= CMP_W'(bound);
  assign closing     = item.last || (count_inc == COUNT_FULL);
  assign elapsed_inc = (elapsed == MS_MAX) ? elapsed : elapsed + MS_W'(1);
  assign utt_after   = utterance || speech_hit;
  assign valid_after = speech_valid || speech_hit;
  assign last_after  = speech_hit ? elapsed : last_speech;
  assign gap         = elapsed - last_after;

  // Next session state for the item at hand
  always_comb begin
    energy_sum_next   = energy_sum;
    frame_count_next  = frame_count;
    elapsed_next      = elapsed;
    last_speech_next  = last_speech;
    speech_valid_next = speech_valid;
    utterance_next    = utterance;
    ended_next        = ended;
    reason_next       = reason;
    frames_next       = frames;
    bytes_next        = bytes;
    closed            = 1'b0;
    unique case (op)
      OP_START: begin
        energy_sum_next   = '0;
        frame_count_next  = '0;
        elapsed_next      = '0;
        last_speech_next  = '0;
        speech_valid_next = 1'b0;
        utterance_next    = 1'b0;
        ended_next        = 1'b0;
        reason_next       = CAUSE_RUNNING;
        frames_next       = '0;
        bytes_next        = '0;
      end
      OP_STOP: begin
        if (!ended) begin
          ended_next  = 1'b1;
          reason_next = CAUSE_STOPPED;
        end
      end
      OP_TICK: begin
        if (!ended) begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= cfg.timeout) begin
            ended_next  = 1'b1;
            reason_next = CAUSE_TIMEOUT;
          end
        end
      end
      OP_SAMPLE: begin
        if (!ended) begin
          if (elapsed >= cfg.timeout) begin
            // Drop the sample, the listen window is over
            ended_next  = 1'b1;
            reason_next = CAUSE_TIMEOUT;
          end else begin
            bytes_next = bytes + BYTES_PER_SAMPLE;
            if (closing) begin
              closed           = 1'b1;
              frames_next      = frames + TOTAL_W'(1);
              energy_sum_next  = '0;
              frame_count_next = '0;
              if (speech_hit) begin
                utterance_next    = 1'b1;
                last_speech_next  = elapsed;
                speech_valid_next = 1'b1;
              end
              // Endpoint once speech is followed by enough silence and enough session time
              if (utt_after && valid_after && (gap >= MS_W'(cfg.tail)) &&
                  (elapsed >= MS_W'(cfg.min_utt))) begin
                ended_next  = 1'b1;
                reason_next = CAUSE_ENDPOINT;
              end
            end else begin
              energy_sum_next  = sum_add;
              frame_count_next = count_inc;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Commit state when the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_sum   <= '0;
      frame_count  <= '0;
      elapsed      <= '0;
      last_speech  <= '0;
      speech_valid <= 1'b0;
      utterance    <= 1'b0;
      ended        <= 1'b0;
      reason       <= CAUSE_RUNNING;
      frames       <= '0;
      bytes        <= '0;
    end else if (advance) begin
      energy_sum   <= energy_sum_next;
      frame_count  <= frame_count_next;
      elapsed      <= elapsed_next;
      last_speech  <= last_speech_next;
      speech_valid <= speech_valid_next;
      utterance    <= utterance_next;
      ended        <= ended_next;
      reason       <= reason_next;
      frames       <= frames_next;
      bytes        <= bytes_next;
    end
  end

  assign result.session_done   = ended_next;
  assign result.end_cause      = reason_next;
  assign result.frame_end      = closed;
  assign result.frame_speech   = closed && speech_hit;
  assign result.forward_frame  = closed && utt_after;
  assign result.utterance_seen = utterance_next;
  assign result.frame_total    = frames_next;
  assign result.byte_total     = bytes_next;

  `EVEP_ASSERT(a_count_below_full, frame_count < COUNT_FULL, "frame count reached the frame limit")
  `EVEP_ASSERT(a_cause_matches_end, ended == (reason != CAUSE_RUNNING), "end flag and cause disagree")
  `EVEP_ASSERT(a_end_sticks, advance && ended && (op != OP_START) |=> ended && $stable(reason), "ended session changed without a start")
  `EVEP_ASSERT(a_speech_time_tracks_utt, speech_valid == utterance, "speech time valid out of step with utterance")

endmodule

@@ sv/energy_vad_endpointer.sv @@
// Path: an accepted item is held in the input register, then its result is
// held in the result register until the sink takes it.
// Throughput: one item per cycle unless the result sink stalls; the update is
// a few short adds, one 31 x 12 threshold product and compares between the two registers.
// Reset (rst, synchronous): session cleared and running, registers at defaults.
`include "energy_vad_endpointer_defines.svh"

module energy_vad_endpointer #(
  parameter int unsigned FRAME_MAX = evep_pkg::FRAME_MAX_DEFAULT
) (
  input logic                             clk,
  input logic                             rst,
  evep_in_if.sink                         item_in,
  evep_out_if.source                      result_out,
  input logic                             cfg_write_en,
  input logic [evep_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [evep_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import evep_pkg::*;

  evep_cfg_t          cfg;
  logic               in_valid;
  evep_item_t         item;
  logic               out_valid;
  evep_result_t       result;
  evep_result_t       core_result;
  logic               out_free;
  logic               advance;
  logic signed [31:0] square;

  evep_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .write_en (cfg_write_en),
    .index    (cfg_index),
    .data     (cfg_data),
    .cfg      (cfg)
  );

  evep_core #(.FRAME_MAX(FRAME_MAX)) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (core_result)
  );

  assign out_free      = !out_valid || result_out.ready;
  assign advance       = in_valid && out_free;
  assign item_in.ready = !in_valid || out_free;
  assign square        = item_in.sample_value * item_in.sample_value;

  // Capture an item, squaring the sample on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_in.valid && item_in.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      item.op   <= item_in.operation;
      item.sq   <= square[SQ_W-1:0];
      item.last <= item_in.last_of_frame;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.session_done   = result.session_done;
  assign result_out.end_cause      = result.end_cause;
  assign result_out.frame_end      = result.frame_end;
  assign result_out.frame_speech   = result.frame_speech;
  assign result_out.forward_frame  = result.forward_frame;
  assign result_out.utterance_seen = result.utterance_seen;
  assign result_out.frame_total    = result.frame_total;
  assign result_out.byte_total     = result.byte_total;

endmodule

@@ bench/evep_session_checker.sv @@
`timescale 1ns / 1ps

module evep_session_checker #(
  parameter int unsigned FRAME_LIMIT = evep_pkg::FRAME_MAX_DEFAULT
) (
  input logic                             clk,
  input logic                             rst,
  evep_in_if                              item_mon,
  evep_out_if                             result_mon,
  input logic                             cfg_write_en,
  input logic [evep_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [evep_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                     fail_count,
  output int unsigned                     pending,
  output int unsigned                     live_items,
  output logic                            session_over
);
  import evep_pkg::*;

  // Shadow copy of the configuration registers
  logic [THR_W-1:0]     thr_reg;
  logic [MS_W-1:0]      timeout_reg;
  logic [TAIL_W-1:0]    tail_reg;
  logic [MIN_UTT_W-1:0] min_utt_reg;

  // Shadow copy of the session state
  logic [41:0]        energy_acc;
  logic [11:0]        frame_fill;
  logic [MS_W-1:0]    elapsed;
  logic [MS_W-1:0]    speech_stamp;
  logic               stamp_valid;
  logic               talk_seen;
  logic               ended;
  evep_cause_t        cause;
  logic [TOTAL_W-1:0] frame_count;
  logic [TOTAL_W-1:0] byte_count;

  evep_result_t expected_results[$];

  task automatic clear_session();
    energy_acc    = '0;
    frame_fill    = '0;
    elapsed       = '0;
    speech_stamp  = '0;
    stamp_valid   = 1'b0;
    talk_seen     = 1'b0;
    ended         = 1'b0;
    cause         = CAUSE_RUNNING;
    frame_count   = '0;
    byte_count    = '0;
  endtask

  // Keep the cause of the first end only
  task automatic end_session(input evep_cause_t why);
    if (!ended) begin
      ended = 1'b1;
      cause = why;
    end
  endtask

  // Advance the session by one item and build the result it produces
  task automatic predict_session_step(input logic [1:0] op_bits, input logic [15:0] raw,
                                      input logic last_mark, output evep_result_t res);
    logic               closed;
    logic               speech;
    logic               fwd;
    logic signed [31:0] amp;
    logic [31:0]        sq;
    logic [63:0]        bound;
    closed = 1'b0;
    speech = 1'b0;
    fwd    = 1'b0;
    case (evep_op_t'(op_bits))
      OP_START: begin
        clear_session();
      end
      OP_STOP: begin
        end_session(CAUSE_STOPPED);
      end
      OP_TICK: begin
        if (!ended) begin
          if (elapsed != MS_MAX) elapsed = elapsed + MS_W'(1);
          if (elapsed >= timeout_reg) end_session(CAUSE_TIMEOUT);
        end
      end
      default: begin
        if (!ended) begin
          if (elapsed >= timeout_reg) begin
            // Drop the sample, the session has run out of time
            end_session(CAUSE_TIMEOUT);
          end else begin
            amp        = {{16{raw[15]}}, raw};
            sq         = 32'(amp * amp);
            energy_acc = energy_acc + 42'(sq);
            frame_fill = frame_fill + 12'(1);
            byte_count = byte_count + BYTES_PER_SAMPLE;
            if (last_mark || 32'(frame_fill) >= FRAME_LIMIT) begin
              bound       = 64'(thr_reg) * 64'(THR_SCALE) * 64'(frame_fill);
              closed      = 1'b1;
              speech      = 64'(energy_acc) >= bound;
              frame_count = frame_count + TOTAL_W'(1);
              energy_acc  = '0;
              frame_fill  = '0;
              if (speech) begin
                talk_seen    = 1'b1;
                speech_stamp = elapsed;
                stamp_valid  = 1'b1;
              end
              fwd = talk_seen;
              // Endpoint: enough silence after speech and enough session time
              if (talk_seen && stamp_valid &&
                  (elapsed - speech_stamp) >= MS_W'(tail_reg) &&
                  elapsed >= MS_W'(min_utt_reg)) begin
                end_session(CAUSE_ENDPOINT);
              end
            end
          end
        end
      end
    endcase
    res.session_done   = ended;
    res.end_cause      = cause;
    res.frame_end      = closed;
    res.frame_speech   = speech;
    res.forward_frame  = fwd;
    res.utterance_seen = talk_seen;
    res.frame_total    = frame_count;
    res.byte_total     = byte_count;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    evep_result_t want;
    evep_result_t fresh;
    if (rst) begin
      thr_reg      = THR_W'(THR_SCALED_RESET / THR_SCALE);
      timeout_reg  = TIMEOUT_RESET;
      tail_reg     = TAIL_RESET;
      min_utt_reg  = MIN_UTT_RESET;
      clear_session();
      expected_results.delete();
      fail_count   = 0;
      pending      = 0;
      live_items   = 0;
      session_over = 1'b0;
    end else begin
      // Track register writes
      if (cfg_write_en) begin
        case (cfg_index)
          REG_SPEECH_THRESHOLD: thr_reg     = cfg_data[THR_W-1:0];
          REG_LISTEN_TIMEOUT:   timeout_reg = cfg_data[MS_W-1:0];
          REG_TAIL_SILENCE:     tail_reg    = cfg_data[TAIL_W-1:0];
          REG_MIN_UTTERANCE:    min_utt_reg = cfg_data[MIN_UTT_W-1:0];
          default: ;
        endcase
      end

      // Compare each delivered result with the oldest prediction
      if (result_mon.valid && result_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no item waiting: frame_total %0d byte_total %0d",
                 result_mon.frame_total, result_mon.byte_total);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("session_done", TOTAL_W'(want.session_done),
                      TOTAL_W'(result_mon.session_done));
          check_field("end_cause", TOTAL_W'(want.end_cause), TOTAL_W'(result_mon.end_cause));
          check_field("frame_end", TOTAL_W'(want.frame_end), TOTAL_W'(result_mon.frame_end));
          check_field("frame_speech", TOTAL_W'(want.frame_speech),
                      TOTAL_W'(result_mon.frame_speech));
          check_field("forward_frame", TOTAL_W'(want.forward_frame),
                      TOTAL_W'(result_mon.forward_frame));
          check_field("utterance_seen", TOTAL_W'(want.utterance_seen),
                      TOTAL_W'(result_mon.utterance_seen));
          check_field("frame_total", want.frame_total, result_mon.frame_total);
          check_field("byte_total", want.byte_total, result_mon.byte_total);
        end
      end

      // Predict the result of each accepted item
      if (item_mon.valid && item_mon.ready) begin
        if (evep_op_t'(item_mon.operation) == OP_START || !ended) live_items++;
        predict_session_step(item_mon.operation, item_mon.sample_value,
                             item_mon.last_of_frame, fresh);
        expected_results.push_back(fresh);
      end

      pending      = expected_results.size();
      session_over = ended;
    end
  end

endmodule

@@ bench/tb_energy_vad_endpointer.sv @@
`timescale 1ns / 1ps

module tb_energy_vad_endpointer;
  import evep_pkg::*;

  localparam int unsigned LIVE_GOAL   = 1550;
  localparam longint      LIMIT_NS    = 30_000_000;
  localparam int unsigned THR_TOP     = 1073742;
  localparam int unsigned TIMEOUT_TOP = 600000;
  localparam int unsigned TAIL_TOP    = 60000;
  localparam int unsigned MIN_UTT_TOP = 60000;

  typedef enum int {KIND_SPEECH, KIND_QUIET, KIND_MIXED} frame_kind_t;
  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_THIRDS, STALL_LONG} stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned live_items;
  logic        session_over;
  int unsigned burst_left;
  int unsigned live_goal;

  stall_mode_t stall_mode  = STALL_NONE;
  int unsigned mode_left   = 0;
  int unsigned stall_phase = 0;

  evep_in_if  item_if ();
  evep_out_if result_if ();

  always #6 clk = ~clk;

  energy_vad_endpointer i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_in      (item_if),
    .result_out   (result_if),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  evep_session_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_mon     (item_if),
    .result_mon   (result_if),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .live_items   (live_items),
    .session_over (session_over)
  );

  // Stall the result side on a changing pattern
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_LONG));
      mode_left  = $urandom_range(40, 300);
    end
    mode_left--;
    stall_phase++;
    case (stall_mode)
      STALL_NONE:   result_if.ready <= 1'b1;
      STALL_RANDOM: result_if.ready <= ($urandom_range(0, 9) < 7);
      STALL_THIRDS: result_if.ready <= (stall_phase % 3 == 0);
      default:      result_if.ready <= (stall_phase % 16 < 4);
    endcase
  end

  // Hand over one item, idling between bursts; starts and ends at a falling edge
  task automatic send_item(input evep_op_t op, input logic [15:0] value, input logic last_mark);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
      if (gap != 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    item_if.valid         <= 1'b1;
    item_if.operation     <= op;
    item_if.sample_value  <= value;
    item_if.last_of_frame <= last_mark;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  function automatic logic [15:0] draw_sample(input frame_kind_t kind);
    logic [15:0] v;
    case (kind)
      KIND_SPEECH: v = ($urandom_range(0, 49) == 0) ? 16'h8000 : 16'($urandom_range(1500, 32767));
      KIND_QUIET:  v = 16'($urandom_range(0, 200));
      default:     return 16'($urandom_range(0, 65535));
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Random op with random stray fields
  task automatic send_noise();
    send_item(evep_op_t'($urandom_range(OP_SAMPLE, OP_START)), 16'($urandom_range(0, 65535)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_frame(input frame_kind_t kind, input int unsigned len, input logic mark_end);
    for (int unsigned i = 0; i < len; i++) begin
      // Break the frame now and then with a stray item
      if ($urandom_range(0, 29) == 0) begin
        if ($urandom_range(0, 3) == 0) send_noise();
        else send_item(OP_TICK, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end
      send_item(OP_SAMPLE, draw_sample(kind), mark_end && (i == len - 1));
    end
  endtask

  // Drop valid and let every outstanding result come back
  task automatic drain();
    item_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_config(input int unsigned thr, input int unsigned timeout_ms,
                              input int unsigned tail_ms, input int unsigned min_ms);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_SPEECH_THRESHOLD;
    cfg_data     <= CFG_DATA_W'(thr);
    @(negedge clk);
    cfg_index    <= REG_LISTEN_TIMEOUT;
    cfg_data     <= CFG_DATA_W'(timeout_ms);
    @(negedge clk);
    cfg_index    <= REG_TAIL_SILENCE;
    cfg_data     <= CFG_DATA_W'(tail_ms);
    @(negedge clk);
    cfg_index    <= REG_MIN_UTTERANCE;
    cfg_data     <= CFG_DATA_W'(min_ms);
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Sessions of random frames and ticks, restarted once they end
  task automatic run_phase(input int unsigned quota);
    int unsigned stop_at;
    int unsigned len;
    int unsigned pick;
    frame_kind_t kind;
    stop_at = live_items + quota;
    send_item(OP_START, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    while (live_items < stop_at) begin
      if (session_over) begin
        repeat ($urandom_range(0, 2)) send_noise();
        send_item(OP_START, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) kind = KIND_SPEECH;
      else if (pick < 8) kind = KIND_QUIET;
      else kind = KIND_MIXED;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      send_frame(kind, len, 1'b1);
      repeat ($urandom_range(0, 3)) begin
        send_item(OP_TICK, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 49) == 0) begin
        send_item(OP_STOP, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int unsigned thr;
    int unsigned timeout_ms;
    int unsigned tail_ms;
    int unsigned min_ms;
    int unsigned quota;
    item_if.valid         = 1'b0;
    item_if.operation     = OP_SAMPLE;
    item_if.sample_value  = '0;
    item_if.last_of_frame = 1'b0;
    cfg_write_en          = 1'b0;
    cfg_index             = REG_SPEECH_THRESHOLD;
    cfg_data              = '0;
    burst_left            = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Speech then silence up to an endpoint, ignored items, stop
    write_config(300, 50, 2, 3);
    send_item(OP_START, 16'h8000, 1'b1);
    send_item(OP_SAMPLE, 16'h7fff, 1'b0);
    send_item(OP_SAMPLE, 16'h8000, 1'b1);
    send_item(OP_SAMPLE, 16'h0000, 1'b1);
    send_item(OP_TICK, 16'hffff, 1'b1);
    send_item(OP_TICK, 16'h0000, 1'b0);
    send_item(OP_TICK, 16'h0000, 1'b0);
    send_item(OP_SAMPLE, 16'h0001, 1'b1);
    send_item(OP_SAMPLE, 16'hffff, 1'b1);
    send_item(OP_TICK, 16'h0000, 1'b0);
    send_item(OP_STOP, 16'h5555, 1'b1);
    send_item(OP_START, 16'h8000, 1'b1);
    send_item(OP_SAMPLE, 16'h0005, 1'b0);
    send_item(OP_STOP, 16'haaaa, 1'b0);
    send_item(OP_SAMPLE, 16'h7fff, 1'b1);

    // Top threshold rejects a full-scale frame; timeout at a tick
    drain();
    write_config(THR_TOP, 3, 0, 0);
    send_item(OP_START, 16'h0000, 1'b0);
    send_item(OP_SAMPLE, 16'h8000, 1'b1);
    send_item(OP_TICK, 16'h0000, 1'b0);
    send_item(OP_TICK, 16'h0000, 1'b0);
    send_item(OP_SAMPLE, 16'h7fff, 1'b1);
    send_item(OP_TICK, 16'h0000, 1'b0);

    // Zero timeout ends the session at the first sample
    drain();
    write_config(0, 0, TAIL_TOP, MIN_UTT_TOP);
    send_item(OP_START, 16'h0000, 1'b0);
    send_item(OP_SAMPLE, 16'h0000, 1'b1);

    // Frame closed by length alone
    drain();
    write_config(1, TIMEOUT_TOP, TAIL_TOP, MIN_UTT_TOP);
    send_item(OP_START, 16'h0000, 1'b0);
    send_frame(KIND_MIXED, FRAME_MAX_DEFAULT, 1'b0);
    send_frame(KIND_QUIET, 3, 1'b1);

    // Random phases over a spread of settings
    live_goal = live_items + LIVE_GOAL;
    while (live_items < live_goal) begin
      drain();
      case ($urandom_range(0, 5))
        0:       thr = 0;
        1:       thr = THR_TOP;
        2:       thr = 300;
        default: thr = $urandom_range(50, 2000);
      endcase
      case ($urandom_range(0, 7))
        0:       timeout_ms = 0;
        1:       timeout_ms = TIMEOUT_TOP;
        2, 3:    timeout_ms = $urandom_range(20, 150);
        default: timeout_ms = $urandom_range(200, 3000);
      endcase
      case ($urandom_range(0, 5))
        0:       tail_ms = 0;
        1:       tail_ms = TAIL_TOP;
        default: tail_ms = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 5))
        0:       min_ms = 0;
        1:       min_ms = MIN_UTT_TOP;
        default: min_ms = $urandom_range(1, 20);
      endcase
      write_config(thr, timeout_ms, tail_ms, min_ms);
      quota = (timeout_ms == 0) ? 20 : $urandom_range(120, 260);
      run_phase(quota);
    end

    drain();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
